// File: hw/rtl/smfd_pkg.sv
// ----------------------------------------------------------------------------
// smfd_pkg: shared types and constants of the short message frame decoder
// Frame layout constants, status codes, register indexes, the controller /
// datapath interface structs and the CRC-16/CCITT-FALSE byte update.
// ----------------------------------------------------------------------------
package smfd_pkg;

  // Header is eight bytes: flags, source (2), destination (2), id, length, rsvd
  localparam int unsigned HDR_SIZE = 8;
  localparam int unsigned HDR_AW   = 3;
  localparam int unsigned HDR_LEN  = 6;
  localparam int unsigned HDR_ID   = 5;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CRC_ERR   = 3'd1,
    ST_LEN_ERR   = 3'd2,
    ST_COUNT_ERR = 3'd3,
    ST_INDEX_ERR = 3'd4,
    ST_TYPE_ERR  = 3'd5
  } status_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_DATA_TYPE = 2'd0;
  localparam logic [1:0] CFG_ACK_TYPE  = 2'd1;
  localparam logic [1:0] CFG_MAX_FRAGS = 2'd2;

  // Controller states
  typedef enum logic [1:0] {
    S_RECV,
    S_CHECK,
    S_EMIT,
    S_ERR
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic take_byte;  // input byte transfer this cycle
    logic rd_first;   // start payload readout at slot zero
    logic rd_next;    // advance payload readout by one slot
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic final_byte; // byte on the input is the last of the frame
    logic status_ok;  // latched frame check passed
    logic rd_last;    // readout sits on the final payload slot
  } dp_stat_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hw/rtl/short_message_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// short_message_frame_decoder_top: received short message frame checker
// Checks frames of FRAME_LENGTH bytes (header, payload, CRC-16/CCITT-FALSE)
// and delivers either one error status or the header with each payload byte.
//
// Input channel (in_*): one frame byte per transfer; in_frame_start forces the
// byte to be byte zero. Bytes are taken one per cycle while receiving.
// Output channel (out_*): after the final byte the input is stalled for the
// check state, then the results start: a single status result with out_last set, or
// PAYLOAD_LENGTH results, one per cycle while out_stall is low, the final one
// with out_last set. A stalled result holds its fields; the block accepts no
// input until the frame's last result is transferred.
// Configuration (cfg_*): write while idle; index 0 data type code, 1 ack type
// code, 2 maximum fragment count; other indexes are ignored.
// Reset: position zero, CRC preset, registers to 1, 2, 3, nothing pending.
// ----------------------------------------------------------------------------
module short_message_frame_decoder_top #(
  parameter int FRAME_LENGTH   = 64,
  parameter int PAYLOAD_LENGTH = 54
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_msg_type,
  output logic [1:0]  out_frag_count,
  output logic [1:0]  out_frag_index,
  output logic [15:0] out_source_addr,
  output logic [15:0] out_dest_addr,
  output logic [7:0]  out_message_id,
  output logic [7:0]  out_payload_len,
  output logic [7:0]  out_payload_byte,
  output logic        out_last
);
  import smfd_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Controller
  smfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath
  smfd_datapath #(
    .FRAME_LENGTH   (FRAME_LENGTH),
    .PAYLOAD_LENGTH (PAYLOAD_LENGTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .rx_byte      (in_rx_byte),
    .frame_start  (in_frame_start),
    .cmd          (cmd),
    .stat         (stat),
    .status       (out_status),
    .msg_type     (out_msg_type),
    .frag_count   (out_frag_count),
    .frag_index   (out_frag_index),
    .source_addr  (out_source_addr),
    .dest_addr    (out_dest_addr),
    .message_id   (out_message_id),
    .payload_len  (out_payload_len),
    .payload_byte (out_payload_byte),
    .last         (out_last)
  );

endmodule

// File: hw/rtl/smfd_ctrl.sv
// ----------------------------------------------------------------------------
// smfd_ctrl: frame decoder controller
// Sequences byte reception, the frame check and the readout of results.
// ----------------------------------------------------------------------------
module smfd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  smfd_pkg::dp_stat_t    stat,
  output smfd_pkg::ctrl_cmd_t   cmd
);
  import smfd_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd.take_byte = 1'b0;
    cmd.rd_first  = 1'b0;
    cmd.rd_next   = 1'b0;
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    case (state_r)
      S_RECV: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_byte = 1'b1;
          if (stat.final_byte) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.status_ok) begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_EMIT;
        end else begin
          state_nxt = S_ERR;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (stat.rd_last) begin
            state_nxt = S_RECV;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      S_ERR: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = S_RECV;
        end
      end
      default: begin
        state_nxt = S_RECV;
      end
    endcase
  end

endmodule

// File: hw/rtl/smfd_datapath.sv
// ----------------------------------------------------------------------------
// smfd_datapath: frame decoder datapath
// Byte position, running CRC, header registers, payload buffer, frame check
// and the result fields.
// ----------------------------------------------------------------------------
module smfd_datapath #(
  parameter int FRAME_LENGTH   = 64,
  parameter int PAYLOAD_LENGTH = 54
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [1:0]            cfg_wdata,
  input  logic [7:0]            rx_byte,
  input  logic                  frame_start,
  input  smfd_pkg::ctrl_cmd_t   cmd,
  output smfd_pkg::dp_stat_t    stat,
  output logic [2:0]            status,
  output logic [1:0]            msg_type,
  output logic [1:0]            frag_count,
  output logic [1:0]            frag_index,
  output logic [15:0]           source_addr,
  output logic [15:0]           dest_addr,
  output logic [7:0]            message_id,
  output logic [7:0]            payload_len,
  output logic [7:0]            payload_byte,
  output logic                  last
);
  import smfd_pkg::*;

  localparam int PW = $clog2(FRAME_LENGTH);
  localparam int AW = $clog2(PAYLOAD_LENGTH);
  localparam int CW = ((PW > AW) ? PW : AW) + 1;

  // Configuration registers
  logic [1:0] data_type_r, ack_type_r, max_frags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_type_r <= 2'd1;
      ack_type_r  <= 2'd2;
      max_frags_r <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DATA_TYPE: data_type_r <= cfg_wdata;
        CFG_ACK_TYPE:  ack_type_r  <= cfg_wdata;
        CFG_MAX_FRAGS: max_frags_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Position and CRC, with resync on frame_start
  logic [PW-1:0] pos_r, pos_eff;
  logic [15:0]   crc_r, crc_base;
  logic [CW-1:0] pos_w, pay_off;
  logic          crc_byte, crc_lo_byte, final_byte, hdr_byte, pay_byte;

  assign pos_eff     = frame_start ? '0 : pos_r;
  assign crc_base    = frame_start ? CRC_INIT : crc_r;
  assign pos_w       = CW'(pos_eff);
  assign pay_off     = pos_w - CW'(HDR_SIZE);
  assign crc_byte    = pos_w < CW'(FRAME_LENGTH - 2);
  assign crc_lo_byte = pos_w == CW'(FRAME_LENGTH - 2);
  assign final_byte  = pos_w == CW'(FRAME_LENGTH - 1);
  assign hdr_byte    = pos_w < CW'(HDR_SIZE);
  assign pay_byte    = crc_byte && !hdr_byte && (pay_off < CW'(PAYLOAD_LENGTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      crc_r <= CRC_INIT;
    end else if (cmd.take_byte) begin
      if (final_byte) begin
        pos_r <= '0;
        crc_r <= CRC_INIT;
      end else if (crc_byte) begin
        pos_r <= pos_eff + 1'b1;
        crc_r <= crc_feed(crc_base, rx_byte);
      end else begin
        pos_r <= pos_eff + 1'b1;
        crc_r <= crc_base;
      end
    end
  end

  // Header bytes and the low CRC byte
  logic [7:0] hdr_r [HDR_SIZE];
  logic [7:0] crc_lo_r;

  always_ff @(posedge clk) begin
    if (cmd.take_byte && hdr_byte) begin
      hdr_r[pos_eff[HDR_AW-1:0]] <= rx_byte;
    end
    if (cmd.take_byte && crc_lo_byte) begin
      crc_lo_r <= rx_byte;
    end
  end

  // Frame check on the final byte
  logic [1:0] f_type, f_count, f_index;
  status_t    status_nxt, status_r;

  assign f_type  = hdr_r[0][7:6];
  assign f_count = hdr_r[0][5:4];
  assign f_index = hdr_r[0][3:2];

  always_comb begin
    if (crc_r != {rx_byte, crc_lo_r}) begin
      status_nxt = ST_CRC_ERR;
    end else if (hdr_r[HDR_LEN] > 8'(PAYLOAD_LENGTH)) begin
      status_nxt = ST_LEN_ERR;
    end else if (f_count == 2'd0 || f_count > max_frags_r) begin
      status_nxt = ST_COUNT_ERR;
    end else if (f_index >= f_count) begin
      status_nxt = ST_INDEX_ERR;
    end else if (f_type != data_type_r && f_type != ack_type_r) begin
      status_nxt = ST_TYPE_ERR;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && final_byte) begin
      status_r <= status_nxt;
    end
  end

  // Payload buffer with registered read
  logic [7:0]    pay_mem [PAYLOAD_LENGTH];
  logic [7:0]    rd_data_r;
  logic [AW-1:0] rd_idx_r, rd_addr;

  assign rd_addr = cmd.rd_first ? '0 : rd_idx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.take_byte && pay_byte) begin
      pay_mem[pay_off[AW-1:0]] <= rx_byte;
    end
    if (cmd.rd_first || cmd.rd_next) begin
      rd_data_r <= pay_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_first || cmd.rd_next) begin
      rd_idx_r <= rd_addr;
    end
  end

  // Status to the controller
  logic rd_last, err;
  assign rd_last = rd_idx_r == AW'(PAYLOAD_LENGTH - 1);
  assign err     = status_r != ST_OK;

  assign stat.final_byte = final_byte;
  assign stat.status_ok  = !err;
  assign stat.rd_last    = rd_last;

  // Result fields: header and payload byte cleared, last set on an error result
  assign status       = status_r;
  assign msg_type     = err ? 2'd0  : f_type;
  assign frag_count   = err ? 2'd0  : f_count;
  assign frag_index   = err ? 2'd0  : f_index;
  assign source_addr  = err ? 16'd0 : {hdr_r[2], hdr_r[1]};
  assign dest_addr    = err ? 16'd0 : {hdr_r[4], hdr_r[3]};
  assign message_id   = err ? 8'd0  : hdr_r[HDR_ID];
  assign payload_len  = err ? 8'd0  : hdr_r[HDR_LEN];
  assign payload_byte = err ? 8'd0  : rd_data_r;
  assign last         = err ? 1'b1  : rd_last;

endmodule
